// ===== rtl/fet_pkg.sv =====
// shared types and constants for the escape-time iterator
`default_nettype none

package fet_pkg;

    // fixed-point format of the point and constant fields
    localparam int DATA_BITS = 32;
    localparam int FRAC_BITS = 28;
    localparam int COUNT_BITS = 10;
    localparam int LIM_BITS = 11;
    localparam int CFG_IDX_BITS = 2;

    // internal saturating arithmetic
    localparam int WIDE_BITS = 48;
    localparam int MAG_BITS = WIDE_BITS - 1;
    localparam int HALF_BITS = (MAG_BITS + 1) / 2;
    localparam int ACC_BITS = 4 * HALF_BITS;

    typedef logic signed [WIDE_BITS-1:0] wide_t;

    localparam wide_t WIDE_MAX = {1'b0, {(WIDE_BITS - 1){1'b1}}};

    // iteration modes
    localparam logic MODE_JULIA = 1'b0;
    localparam logic MODE_MANDEL = 1'b1;

    typedef struct packed {
        logic                        mode;
        logic signed [DATA_BITS-1:0] c_re;
        logic signed [DATA_BITS-1:0] c_im;
        logic [LIM_BITS-1:0]         max_iter;
    } cfg_t;

    typedef struct packed {
        logic  start;
        wide_t a;
        wide_t b;
    } mul_req_t;

    typedef struct packed {
        logic  done;
        wide_t p;
    } mul_rsp_t;

    typedef struct packed {
        logic                  idle;
        logic                  done;
        logic [COUNT_BITS-1:0] count;
    } seq_stat_t;

endpackage

`default_nettype wire

// ===== rtl/fet_mul.sv =====
// iterative saturating fixed-point multiplier, four half-width partial products
`default_nettype none

module fet_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  fet_pkg::mul_req_t req,
    output fet_pkg::mul_rsp_t rsp
);
    import fet_pkg::*;

    localparam int OP_BITS = 2 * HALF_BITS;
    localparam logic [2:0] STEP_LL = 3'd0;
    localparam logic [2:0] STEP_LH = 3'd1;
    localparam logic [2:0] STEP_HL = 3'd2;
    localparam logic [2:0] STEP_HH = 3'd3;
    localparam logic [2:0] STEP_FINAL = 3'd4;

    // clamped magnitude of a wide operand
    function automatic logic [OP_BITS-1:0] magnitude(input wide_t v);
        logic [WIDE_BITS-1:0] neg_v;
        neg_v = -v;
        if (!v[WIDE_BITS-1])
            magnitude = OP_BITS'(v[MAG_BITS-1:0]);
        else if (v[MAG_BITS-1:0] == '0)
            magnitude = OP_BITS'(WIDE_MAX);
        else
            magnitude = OP_BITS'(neg_v[MAG_BITS-1:0]);
    endfunction

    logic [OP_BITS-1:0]   ua_reg, ua_next;
    logic [OP_BITS-1:0]   ub_reg, ub_next;
    logic                 neg_reg, neg_next;
    logic [2:0]           step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [ACC_BITS-1:0]  acc_reg, acc_next;
    wide_t                p_reg, p_next;

    logic [HALF_BITS-1:0] pa, pb;
    logic [OP_BITS-1:0]   pp;
    logic [ACC_BITS-1:0]  term;
    logic                 over;
    logic [MAG_BITS-1:0]  r;
    logic [WIDE_BITS-1:0] r_ext;

    // partial product select
    always_comb
    begin
        pa = ua_reg[HALF_BITS-1:0];
        pb = ub_reg[HALF_BITS-1:0];
        term = '0;
        pp = pa * pb;
        case (step_reg)
            STEP_LL:
            begin
                pp = pa * pb;
                term = ACC_BITS'(pp);
            end
            STEP_LH:
            begin
                pp = ua_reg[HALF_BITS-1:0] * ub_reg[OP_BITS-1:HALF_BITS];
                term = ACC_BITS'(pp) << HALF_BITS;
            end
            STEP_HL:
            begin
                pp = ua_reg[OP_BITS-1:HALF_BITS] * ub_reg[HALF_BITS-1:0];
                term = ACC_BITS'(pp) << HALF_BITS;
            end
            STEP_HH:
            begin
                pp = ua_reg[OP_BITS-1:HALF_BITS] * ub_reg[OP_BITS-1:HALF_BITS];
                term = ACC_BITS'(pp) << OP_BITS;
            end
            default:
            begin
                term = '0;
            end
        endcase
    end

    // truncate the fraction and saturate the magnitude; the sign is restored at the final step
    always_comb
    begin
        over = |acc_reg[ACC_BITS-1:FRAC_BITS+MAG_BITS];
        r = over ? '1 : acc_reg[FRAC_BITS+MAG_BITS-1:FRAC_BITS];
        r_ext = {1'b0, r};
    end

    // step sequencing
    always_comb
    begin
        ua_next = ua_reg;
        ub_next = ub_reg;
        neg_next = neg_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        acc_next = acc_reg;
        p_next = p_reg;
        if (busy_reg)
        begin
            if (step_reg == STEP_FINAL)
            begin
                p_next = neg_reg ? wide_t'(-r_ext) : wide_t'(r_ext);
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                acc_next = acc_reg + term;
                step_next = step_reg + 3'd1;
            end
        end
        else if (req.start)
        begin
            ua_next = magnitude(req.a);
            ub_next = magnitude(req.b);
            neg_next = req.a[WIDE_BITS-1] ^ req.b[WIDE_BITS-1];
            acc_next = '0;
            step_next = STEP_LL;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= STEP_LL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ua_reg <= ua_next;
        ub_reg <= ub_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        p_reg <= p_next;
    end

    assign rsp.done = done_reg;
    assign rsp.p = p_reg;

endmodule

`default_nettype wire

// ===== rtl/fet_seq.sv =====
// iteration sequencer: z registers, shared saturating adder, multiplier control
`default_nettype none

module fet_seq (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [fet_pkg::DATA_BITS-1:0] point_re,
    input  logic signed [fet_pkg::DATA_BITS-1:0] point_im,
    input  fet_pkg::cfg_t                      cfg,
    input  logic                               take,
    input  fet_pkg::mul_rsp_t                  mul_rsp,
    output fet_pkg::mul_req_t                  mul_req,
    output fet_pkg::seq_stat_t                 stat
);
    import fet_pkg::*;

    localparam int ADD_BITS = WIDE_BITS + 4;
    localparam int CNT_BITS = (COUNT_BITS > LIM_BITS) ? COUNT_BITS : LIM_BITS;
    localparam int BYTE_BITS = 8;
    localparam logic signed [ADD_BITS-1:0] ADD_MAX = ADD_BITS'(WIDE_MAX);
    localparam logic signed [ADD_BITS-1:0] ADD_MIN = -ADD_MAX;
    localparam logic signed [ADD_BITS-1:0] ESC_MANDEL = ADD_BITS'(4) <<< FRAC_BITS;
    localparam logic signed [ADD_BITS-1:0] ESC_JULIA = ADD_BITS'(16) <<< FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_LOOP, S_DONE,
        M_XY, M_DBL, M_NX1, M_NX2, M_Y, M_XX, M_YY, M_SUM,
        J_XX, J_YY, J_XC, J_YC, J_X4, J_Y4, J_T, J_T6, J_NX1, J_NX2,
        J_U, J_U4, J_V, J_V4, J_NY1, J_NY2
    } state_t;

    function automatic logic signed [ADD_BITS-1:0] ext_w(input wide_t v);
        ext_w = {{(ADD_BITS - WIDE_BITS){v[WIDE_BITS-1]}}, v};
    endfunction

    function automatic logic signed [ADD_BITS-1:0] ext_d(
        input logic signed [DATA_BITS-1:0] v);
        ext_d = {{(ADD_BITS - DATA_BITS){v[DATA_BITS-1]}}, v};
    endfunction

    function automatic wide_t sat_wide(input logic signed [ADD_BITS-1:0] v);
        if (v > ADD_MAX)
            sat_wide = WIDE_MAX;
        else if (v < ADD_MIN)
            sat_wide = -WIDE_MAX;
        else
            sat_wide = v[WIDE_BITS-1:0];
    endfunction

    state_t                      state_reg, state_next;
    logic                        issued_reg, issued_next;
    logic [LIM_BITS-1:0]         n_reg, n_next;
    wide_t                       x_reg, x_next;
    wide_t                       y_reg, y_next;
    wide_t                       xsq_reg, xsq_next;
    wide_t                       ysq_reg, ysq_next;
    wide_t                       xcb_reg, xcb_next;
    wide_t                       ycb_reg, ycb_next;
    wide_t                       tmp_reg, tmp_next;
    logic signed [DATA_BITS-1:0] pr_reg, pr_next;
    logic signed [DATA_BITS-1:0] pi_reg, pi_next;

    logic signed [ADD_BITS-1:0]  add_a, add_b, add_sum;
    wide_t                       sat;
    logic signed [ADD_BITS-1:0]  sat_ext;
    logic                        is_mul;
    logic [CNT_BITS-1:0]         lim_w, n_w, cnt_w;

    // multiplier operand select
    always_comb
    begin
        is_mul = 1'b1;
        mul_req.a = x_reg;
        mul_req.b = y_reg;
        unique case (state_reg)
            M_XY:
            begin
                mul_req.a = x_reg;
                mul_req.b = y_reg;
            end
            M_XX, J_XX:
            begin
                mul_req.a = x_reg;
                mul_req.b = x_reg;
            end
            M_YY, J_YY:
            begin
                mul_req.a = y_reg;
                mul_req.b = y_reg;
            end
            J_XC:
            begin
                mul_req.a = xsq_reg;
                mul_req.b = x_reg;
            end
            J_YC:
            begin
                mul_req.a = ysq_reg;
                mul_req.b = y_reg;
            end
            J_X4:
            begin
                mul_req.a = xcb_reg;
                mul_req.b = x_reg;
            end
            J_Y4:
            begin
                mul_req.a = ycb_reg;
                mul_req.b = y_reg;
            end
            J_T:
            begin
                mul_req.a = xsq_reg;
                mul_req.b = ysq_reg;
            end
            J_U:
            begin
                mul_req.a = xcb_reg;
                mul_req.b = y_reg;
            end
            J_V:
            begin
                mul_req.a = x_reg;
                mul_req.b = ycb_reg;
            end
            default:
            begin
                is_mul = 1'b0;
            end
        endcase
        mul_req.start = is_mul && !issued_reg;
    end

    // shared saturating adder operand select
    always_comb
    begin
        add_a = '0;
        add_b = '0;
        unique case (state_reg)
            M_DBL:
            begin
                add_a = ext_w(tmp_reg) <<< 1;
            end
            M_NX1:
            begin
                add_a = ext_w(xsq_reg);
                add_b = -ext_w(ysq_reg);
            end
            M_NX2:
            begin
                add_a = ext_w(xsq_reg);
                add_b = ext_d(pr_reg);
            end
            M_Y:
            begin
                add_a = ext_w(tmp_reg);
                add_b = ext_d(pi_reg);
            end
            M_SUM:
            begin
                add_a = ext_w(xsq_reg);
                add_b = ext_w(ysq_reg);
            end
            J_Y4:
            begin
                add_a = ext_w(tmp_reg);
                add_b = ext_w(mul_rsp.p);
            end
            J_T6:
            begin
                add_a = ext_w(xsq_reg) <<< 2;
                add_b = ext_w(xsq_reg) <<< 1;
            end
            J_NX1:
            begin
                add_a = ext_w(tmp_reg);
                add_b = -ext_w(xsq_reg);
            end
            J_NX2:
            begin
                add_a = ext_w(xsq_reg);
                add_b = ext_d(cfg.c_re);
            end
            J_U4:
            begin
                add_a = ext_w(ysq_reg) <<< 2;
            end
            J_V4:
            begin
                add_a = ext_w(tmp_reg) <<< 2;
            end
            J_NY1:
            begin
                add_a = ext_w(ysq_reg);
                add_b = -ext_w(tmp_reg);
            end
            J_NY2:
            begin
                add_a = ext_w(tmp_reg);
                add_b = ext_d(cfg.c_im);
            end
            default:
            begin
                add_a = '0;
            end
        endcase
        add_sum = add_a + add_b;
        sat = sat_wide(add_sum);
        sat_ext = ext_w(sat);
    end

    // final count with the low-byte replacement
    always_comb
    begin
        lim_w = CNT_BITS'(cfg.max_iter);
        n_w = CNT_BITS'(n_reg);
        cnt_w = (n_reg[BYTE_BITS-1:0] == '0) ? lim_w - CNT_BITS'(1) : n_w;
        stat.count = cnt_w[COUNT_BITS-1:0];
        stat.idle = (state_reg == S_IDLE);
        stat.done = (state_reg == S_DONE);
    end

    // sequencer next state and datapath updates
    always_comb
    begin
        state_next = state_reg;
        issued_next = issued_reg;
        n_next = n_reg;
        x_next = x_reg;
        y_next = y_reg;
        xsq_next = xsq_reg;
        ysq_next = ysq_reg;
        xcb_next = xcb_reg;
        ycb_next = ycb_reg;
        tmp_next = tmp_reg;
        pr_next = pr_reg;
        pi_next = pi_reg;

        if (mul_req.start)
            issued_next = 1'b1;
        if (mul_rsp.done)
            issued_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    pr_next = point_re;
                    pi_next = point_im;
                    n_next = '0;
                    xsq_next = '0;
                    ysq_next = '0;
                    if (cfg.mode == MODE_MANDEL)
                    begin
                        x_next = '0;
                        y_next = '0;
                    end
                    else
                    begin
                        x_next = {{(WIDE_BITS - DATA_BITS){point_re[DATA_BITS-1]}}, point_re};
                        y_next = {{(WIDE_BITS - DATA_BITS){point_im[DATA_BITS-1]}}, point_im};
                    end
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                if (n_reg >= cfg.max_iter)
                    state_next = S_DONE;
                else if (cfg.mode == MODE_MANDEL)
                    state_next = M_XY;
                else
                    state_next = J_XX;
            end
            S_DONE:
            begin
                if (take)
                    state_next = S_IDLE;
            end
            // quadratic iteration
            M_XY:
            begin
                if (mul_rsp.done)
                begin
                    tmp_next = mul_rsp.p;
                    state_next = M_DBL;
                end
            end
            M_DBL:
            begin
                tmp_next = sat;
                state_next = M_NX1;
            end
            M_NX1:
            begin
                xsq_next = sat;
                state_next = M_NX2;
            end
            M_NX2:
            begin
                x_next = sat;
                state_next = M_Y;
            end
            M_Y:
            begin
                y_next = sat;
                state_next = M_XX;
            end
            M_XX:
            begin
                if (mul_rsp.done)
                begin
                    xsq_next = mul_rsp.p;
                    state_next = M_YY;
                end
            end
            M_YY:
            begin
                if (mul_rsp.done)
                begin
                    ysq_next = mul_rsp.p;
                    state_next = M_SUM;
                end
            end
            M_SUM:
            begin
                if (sat_ext > ESC_MANDEL)
                    state_next = S_DONE;
                else
                begin
                    n_next = n_reg + LIM_BITS'(1);
                    state_next = S_LOOP;
                end
            end
            // quartic iteration: powers first, then escape test
            J_XX:
            begin
                if (mul_rsp.done)
                begin
                    xsq_next = mul_rsp.p;
                    state_next = J_YY;
                end
            end
            J_YY:
            begin
                if (mul_rsp.done)
                begin
                    ysq_next = mul_rsp.p;
                    state_next = J_XC;
                end
            end
            J_XC:
            begin
                if (mul_rsp.done)
                begin
                    xcb_next = mul_rsp.p;
                    state_next = J_YC;
                end
            end
            J_YC:
            begin
                if (mul_rsp.done)
                begin
                    ycb_next = mul_rsp.p;
                    state_next = J_X4;
                end
            end
            J_X4:
            begin
                if (mul_rsp.done)
                begin
                    tmp_next = mul_rsp.p;
                    state_next = J_Y4;
                end
            end
            J_Y4:
            begin
                if (mul_rsp.done)
                begin
                    tmp_next = sat;
                    if (sat_ext > ESC_JULIA)
                        state_next = S_DONE;
                    else
                        state_next = J_T;
                end
            end
            // real part: x^4 + y^4 - 6 x^2 y^2 + k_re
            J_T:
            begin
                if (mul_rsp.done)
                begin
                    xsq_next = mul_rsp.p;
                    state_next = J_T6;
                end
            end
            J_T6:
            begin
                xsq_next = sat;
                state_next = J_NX1;
            end
            J_NX1:
            begin
                xsq_next = sat;
                state_next = J_NX2;
            end
            J_NX2:
            begin
                xsq_next = sat;
                state_next = J_U;
            end
            // imaginary part: 4 x^3 y - 4 x y^3 + k_im
            J_U:
            begin
                if (mul_rsp.done)
                begin
                    ysq_next = mul_rsp.p;
                    state_next = J_U4;
                end
            end
            J_U4:
            begin
                ysq_next = sat;
                state_next = J_V;
            end
            J_V:
            begin
                if (mul_rsp.done)
                begin
                    tmp_next = mul_rsp.p;
                    state_next = J_V4;
                end
            end
            J_V4:
            begin
                tmp_next = sat;
                state_next = J_NY1;
            end
            J_NY1:
            begin
                tmp_next = sat;
                state_next = J_NY2;
            end
            J_NY2:
            begin
                y_next = sat;
                x_next = xsq_reg;
                n_next = n_reg + LIM_BITS'(1);
                state_next = S_LOOP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            issued_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            issued_reg <= issued_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        x_reg <= x_next;
        y_reg <= y_next;
        xsq_reg <= xsq_next;
        ysq_reg <= ysq_next;
        xcb_reg <= xcb_next;
        ycb_reg <= ycb_next;
        tmp_reg <= tmp_next;
        pr_reg <= pr_next;
        pi_reg <= pi_next;
    end

endmodule

`default_nettype wire

// ===== rtl/fractal_escape_time_iterator.sv =====
// escape-time iterator top level: configuration registers, handshake, output register
// each Mandelbrot or quartic Julia iteration steps through its states, plus the limit check and the
// output hand-off at the end; an escape cuts the loop short, max_iterations caps it
// each product goes through the shared 24x24 multiplier step by step, each add through the shared adder
// throughput: one item in work; the next is taken the cycle after a result is registered
// rst_n clears control state and loads the configuration reset values at once
`default_nettype none

module fractal_escape_time_iterator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [fet_pkg::DATA_BITS-1:0]  point_re,
    input  logic signed [fet_pkg::DATA_BITS-1:0]  point_im,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [fet_pkg::COUNT_BITS-1:0]        escape_count,
    input  logic                                  cfg_we,
    input  logic [fet_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [fet_pkg::DATA_BITS-1:0]         cfg_wdata
);
    import fet_pkg::*;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MODE,
        REG_C_RE,
        REG_C_IM,
        REG_MAX_ITER
    } cfg_idx_t;

    localparam logic signed [DATA_BITS-1:0] RESET_C_RE = DATA_BITS'(161061274);
    localparam logic signed [DATA_BITS-1:0] RESET_C_IM = DATA_BITS'(13421773);
    localparam logic [LIM_BITS-1:0] RESET_MAX_ITER = LIM_BITS'(256);

    cfg_t                  cfg_reg, cfg_next;
    logic                  out_valid_reg, out_valid_next;
    logic [COUNT_BITS-1:0] escape_count_reg, escape_count_next;

    seq_stat_t             stat;
    mul_req_t              mul_req;
    mul_rsp_t              mul_rsp;
    logic                  start;
    logic                  take;

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_MODE:     cfg_next.mode = cfg_wdata[0];
                REG_C_RE:     cfg_next.c_re = cfg_wdata;
                REG_C_IM:     cfg_next.c_im = cfg_wdata;
                REG_MAX_ITER: cfg_next.max_iter = cfg_wdata[LIM_BITS-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    // input and output handshake
    assign in_ready = stat.idle;
    assign start = in_valid && stat.idle;
    assign take = stat.done && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        escape_count_next = escape_count_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (take)
        begin
            out_valid_next = 1'b1;
            escape_count_next = stat.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode <= MODE_MANDEL;
            cfg_reg.c_re <= RESET_C_RE;
            cfg_reg.c_im <= RESET_C_IM;
            cfg_reg.max_iter <= RESET_MAX_ITER;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        escape_count_reg <= escape_count_next;
    end

    assign out_valid = out_valid_reg;
    assign escape_count = escape_count_reg;

    // sequencer and shared multiplier
    fet_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .point_re (point_re),
        .point_im (point_im),
        .cfg      (cfg_reg),
        .take     (take),
        .mul_rsp  (mul_rsp),
        .mul_req  (mul_req),
        .stat     (stat)
    );

    fet_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/fet_checker.sv =====
// port-level checks for the escape-time iterator, bound to the top level
`default_nettype none

module fet_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [fet_pkg::COUNT_BITS-1:0] escape_count
);
    import fet_pkg::*;

    logic [1:0] pend_reg, pend_next;
    logic       in_acc, out_acc;

    // items accepted and not yet delivered
    assign in_acc = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_acc && !out_acc)
            pend_next = pend_reg + 2'd1;
        else if (out_acc && !in_acc)
            pend_next = pend_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 2'd0;
        else
            pend_reg <= pend_next;
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(escape_count))
        else $error("result changed while stalled");

    // block is busy right after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("ready right after an accepted item");

    // no result without an item in flight
    a_out_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result without an accepted item");

    // ready only with at most one item in flight
    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> pend_reg == 2'd0 || pend_reg == 2'd1)
        else $error("ready with two items in flight");

endmodule

bind fractal_escape_time_iterator fet_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .escape_count (escape_count)
);

`default_nettype wire

// ===== dv/escape_count_checker.sv =====
// register map and escape-count scoreboard for the escape-time iterator testbench
`timescale 1ns / 1ps

package fet_tb_pkg;

    // configuration register indexes
    typedef enum logic [fet_pkg::CFG_IDX_BITS-1:0] {
        REG_MODE     = 0,
        REG_C_RE     = 1,
        REG_C_IM     = 2,
        REG_MAX_ITER = 3
    } cfg_reg_e;

endpackage

module escape_count_checker
    import fet_pkg::*;
    import fet_tb_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic signed [DATA_BITS-1:0] point_re,
    input  logic signed [DATA_BITS-1:0] point_im,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [COUNT_BITS-1:0]       escape_count,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [DATA_BITS-1:0]        cfg_wdata,
    output int                          errors,
    output int                          pending,
    output int                          checked
);

    typedef struct {
        logic signed [DATA_BITS-1:0] re;
        logic signed [DATA_BITS-1:0] im;
        logic [COUNT_BITS-1:0]       count;
    } count_exp_t;

    localparam longint SAT_LIM = longint'(WIDE_MAX);
    localparam longint MANDEL_BOUND = 64'sd4 <<< FRAC_BITS;
    localparam longint QUARTIC_BOUND = 64'sd16 <<< FRAC_BITS;

    // shadow copy of the configuration registers
    logic                 cfg_mode;
    longint               cfg_c_re;
    longint               cfg_c_im;
    logic [LIM_BITS-1:0]  cfg_lim;

    count_exp_t expected_counts[$];

    // symmetric saturation of the wide internal values
    function automatic longint sat_wide(longint v);
        if (v > SAT_LIM)
            return SAT_LIM;
        if (v < -SAT_LIM)
            return -SAT_LIM;
        return v;
    endfunction

    // fixed-point product: exact magnitude, truncated, then saturated
    function automatic longint qmul(longint a, longint b);
        logic         neg;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] mag;
        neg = (a < 0) != (b < 0);
        a = sat_wide(a);
        b = sat_wide(b);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        mag = ({64'd0, ua} * {64'd0, ub}) >> FRAC_BITS;
        if (mag > 128'(SAT_LIM))
            mag = 128'(SAT_LIM);
        return neg ? -$signed(mag[63:0]) : $signed(mag[63:0]);
    endfunction

    // z = z^2 + c from zero, escape once |z|^2 > 4
    function automatic int mandel_iters(longint cx, longint cy, logic [LIM_BITS-1:0] lim);
        longint x;
        longint y;
        longint xsq;
        longint ysq;
        longint nx;
        int     n;
        x = 0;
        y = 0;
        xsq = 0;
        ysq = 0;
        for (n = 0; n < lim; n++) begin
            nx = sat_wide(sat_wide(xsq - ysq) + cx);
            y = sat_wide(sat_wide(2 * qmul(x, y)) + cy);
            x = nx;
            xsq = qmul(x, x);
            ysq = qmul(y, y);
            if (sat_wide(xsq + ysq) > MANDEL_BOUND)
                break;
        end
        return n;
    endfunction

    // z = z^4 + k from the point, escape test x^4 + y^4 > 16 ahead of the update
    function automatic int julia_iters(longint x, longint y, logic [LIM_BITS-1:0] lim);
        longint xsq;
        longint ysq;
        longint xcb;
        longint ycb;
        longint sum4;
        longint nx;
        longint ny;
        int     n;
        for (n = 0; n < lim; n++) begin
            xsq = qmul(x, x);
            ysq = qmul(y, y);
            xcb = qmul(xsq, x);
            ycb = qmul(ysq, y);
            sum4 = sat_wide(qmul(xcb, x) + qmul(ycb, y));
            if (sum4 > QUARTIC_BOUND)
                break;
            nx = sat_wide(sum4 - sat_wide(6 * qmul(xsq, ysq)));
            nx = sat_wide(nx + cfg_c_re);
            ny = sat_wide(sat_wide(4 * qmul(xcb, y)) - sat_wide(4 * qmul(x, ycb)));
            ny = sat_wide(ny + cfg_c_im);
            x = nx;
            y = ny;
        end
        return n;
    endfunction

    // count with the low-byte-zero replacement, masked to the port width
    function automatic logic [COUNT_BITS-1:0] predict_count(logic signed [DATA_BITS-1:0] re,
                                                            logic signed [DATA_BITS-1:0] im);
        logic [63:0] n;
        if (cfg_mode == MODE_MANDEL)
            n = 64'(mandel_iters(longint'(re), longint'(im), cfg_lim));
        else
            n = 64'(julia_iters(longint'(re), longint'(im), cfg_lim));
        if (n[7:0] == 8'd0)
            n = 64'(cfg_lim) - 64'd1;
        return n[COUNT_BITS-1:0];
    endfunction

    // watch config writes, accepted points and returned counts
    always @(posedge clk or negedge rst_n) begin : watch
        count_exp_t want;
        count_exp_t got_for;
        if (!rst_n) begin
            cfg_mode = MODE_MANDEL;
            cfg_c_re = 161061274;
            cfg_c_im = 13421773;
            cfg_lim = 11'd256;
            expected_counts.delete();
            errors = 0;
            pending = 0;
            checked = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MODE:     cfg_mode = cfg_wdata[0];
                    REG_C_RE:     cfg_c_re = longint'($signed(cfg_wdata));
                    REG_C_IM:     cfg_c_im = longint'($signed(cfg_wdata));
                    REG_MAX_ITER: cfg_lim = cfg_wdata[LIM_BITS-1:0];
                    default:      ;
                endcase
            end
            if (in_valid && in_ready) begin
                want.re = point_re;
                want.im = point_im;
                want.count = predict_count(point_re, point_im);
                expected_counts.push_back(want);
            end
            if (out_valid && out_ready) begin
                if (expected_counts.size() == 0) begin
                    $display("%0t: unexpected escape_count %0d with no point outstanding",
                             $time, escape_count);
                    errors++;
                end
                else begin
                    got_for = expected_counts.pop_front();
                    checked++;
                    if (escape_count !== got_for.count) begin
                        $display("%0t: escape_count for point (%0d, %0d): expected %0d, got %0d",
                                 $time, got_for.re, got_for.im, got_for.count, escape_count);
                        errors++;
                    end
                end
            end
            pending = expected_counts.size();
        end
    end

endmodule

// ===== dv/fractal_escape_time_iterator_tb.sv =====
// stimulus, clock, reset and verdict for the escape-time iterator testbench
`timescale 1ns / 1ps

module fractal_escape_time_iterator_tb;
    import fet_pkg::*;
    import fet_tb_pkg::*;

    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEMS_PER_SETTING = 35;
    localparam int RAND_SPAN = 671088640;  // 2.5 in Q4.28
    localparam logic signed [DATA_BITS-1:0] FX_ONE = 32'sh1000_0000;
    localparam logic signed [DATA_BITS-1:0] FX_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_BITS-1:0] FX_MIN = 32'sh8000_0000;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic signed [DATA_BITS-1:0] point_re;
    logic signed [DATA_BITS-1:0] point_im;
    logic                        out_valid;
    logic                        out_ready;
    logic [COUNT_BITS-1:0]       escape_count;
    logic                        cfg_we;
    logic [CFG_IDX_BITS-1:0]     cfg_index;
    logic [DATA_BITS-1:0]        cfg_wdata;

    int fails;
    int pending;
    int checked;
    int src_idle_pct;
    int sink_stall_pct;
    int hold_reqs;
    int hold_seen;
    int hold_cnt;
    int cycles;
    int points_sent;
    int settings_used;

    fractal_escape_time_iterator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .point_re     (point_re),
        .point_im     (point_im),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .escape_count (escape_count),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    escape_count_checker u_escape_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .point_re     (point_re),
        .point_im     (point_im),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .escape_count (escape_count),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .errors       (fails),
        .pending      (pending),
        .checked      (checked)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run-length guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d escape counts outstanding", cycles, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold when one is requested
    always @(negedge clk)
    begin
        if (hold_reqs != hold_seen)
        begin
            hold_seen = hold_reqs;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // offer one point, with random idle cycles ahead of it; returns at a falling edge
    task automatic send_point(input logic signed [DATA_BITS-1:0] re,
                              input logic signed [DATA_BITS-1:0] im);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        point_re <= re;
        point_im <= im;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        points_sent++;
        @(negedge clk);
    endtask

    // stop offering and wait until every escape count has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // write all four registers once the block is idle
    task automatic set_config(input logic m, input logic [DATA_BITS-1:0] cre,
                              input logic [DATA_BITS-1:0] cim, input logic [LIM_BITS-1:0] lim);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= REG_MODE;
        cfg_wdata <= {{(DATA_BITS - 1){1'b0}}, m};
        @(negedge clk);
        cfg_index <= REG_C_RE;
        cfg_wdata <= cre;
        @(negedge clk);
        cfg_index <= REG_C_IM;
        cfg_wdata <= cim;
        @(negedge clk);
        cfg_index <= REG_MAX_ITER;
        cfg_wdata <= {{(DATA_BITS - LIM_BITS){1'b0}}, lim};
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // mostly points inside +/-2.5, some full-range and some corners
    function automatic logic signed [DATA_BITS-1:0] rand_coord();
        case ($urandom_range(9))
            0: return $urandom();
            1: return $urandom_range(1) ? FX_MAX : FX_MIN;
            default: return $urandom_range(2 * RAND_SPAN) - RAND_SPAN;
        endcase
    endfunction

    // julia constant: mostly within +/-1.0, sometimes anything
    function automatic logic [DATA_BITS-1:0] rand_const();
        if ($urandom_range(3) == 0)
            return $urandom();
        return $urandom_range(2 * FX_ONE) - FX_ONE;
    endfunction

    // a few random settings with small limits, each followed by a batch of points
    task automatic run_phase(input int src_pct, input int sink_pct);
        int s;
        int k;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        for (s = 0; s < 3; s++)
        begin
            set_config(logic'($urandom_range(1)), rand_const(), rand_const(),
                       LIM_BITS'($urandom_range(2, 20)));
            for (k = 0; k < ITEMS_PER_SETTING; k++)
                send_point(rand_coord(), rand_coord());
        end
    endtask

    initial
    begin : stimulus
        int k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        point_re = '0;
        point_im = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_MODE;
        cfg_wdata = '0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_reqs = 0;
        points_sent = 0;
        settings_used = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: Mandelbrot, limit 256; bounded points and saturating corners
        send_point('0, '0);
        send_point(-FX_ONE, '0);
        send_point(-2 * FX_ONE, '0);
        send_point(FX_MAX, FX_MAX);
        send_point(FX_MIN, FX_MIN);
        send_point(FX_MAX, FX_MIN);
        send_point(FX_ONE / 4, FX_ONE / 2);

        // quartic Julia with the reset constant, incl. a point right on the threshold
        set_config(MODE_JULIA, 32'd161061274, 32'd13421773, 11'd256);
        send_point('0, '0);
        send_point(FX_MAX, FX_MAX);
        send_point(FX_MIN, '0);
        send_point(FX_ONE / 2, -FX_ONE / 2);
        send_point(2 * FX_ONE, '0);

        // extreme constants with the largest limit the register holds
        set_config(MODE_JULIA, FX_MAX, FX_MIN, 11'd2047);
        send_point('0, '0);
        send_point(FX_ONE, FX_ONE);

        // limit of zero and one: replacement wraps
        set_config(MODE_MANDEL, '0, '0, 11'd0);
        send_point('0, '0);
        set_config(MODE_MANDEL, '0, '0, 11'd1);
        send_point('0, '0);
        send_point(3 * FX_ONE, '0);

        // large limits: bounded point runs to the end, count masked
        set_config(MODE_MANDEL, '0, '0, 11'd1024);
        send_point('0, '0);
        send_point(FX_ONE, '0);
        set_config(MODE_MANDEL, '0, '0, 11'd2047);
        send_point(-FX_ONE, '0);
        send_point(FX_ONE / 2, FX_ONE / 2);

        // quartic with zero constant and the smallest usual limit
        set_config(MODE_JULIA, '0, '0, 11'd2);
        send_point(FX_ONE, '0);
        send_point(2 * FX_ONE + 1, '0);

        // random part under different idle and stall mixes
        run_phase(0, 0);
        run_phase(70, 0);
        run_phase(0, 70);
        run_phase(8, 8);

        // long output hold while points keep coming, so the input backs up
        src_idle_pct = 0;
        sink_stall_pct = 0;
        set_config(MODE_MANDEL, '0, '0, 11'd4);
        hold_reqs++;
        for (k = 0; k < 10; k++)
            send_point(rand_coord(), rand_coord());

        drain();
        repeat (40) @(negedge clk);

        $display("%0d points over %0d register settings in both modes, limits 0 to 2047,",
                 points_sent, settings_used);
        $display("idle, stall and long-hold mixes; %0d escape counts compared, %0d bad",
                 checked, fails);
        if (fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
